// ===== hdl/ccds_pkg.sv =====
// Shared types and constants for the channel clamp / deadband / smoother unit.
// No dependencies; used by the interfaces, the conditioning datapath and the top level.
package ccds_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_COUNT = 5'(CHANNELS);

    localparam int US_W    = 12;
    localparam int CH_W    = 3;
    localparam int ALPHA_W = 9;
    localparam int DB_W    = 8;
    localparam int FILT_W  = 20;   // Q12.8
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_FAILSAFE = 2'd1,
        CMD_RESET    = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_US       = 3'd0,
        REG_MAX_US       = 3'd1,
        REG_CENTER_US    = 3'd2,
        REG_BAND_HALF_US = 3'd3,
        REG_ALPHA_Q8     = 3'd4,
        REG_FS_THROTTLE  = 3'd5,
        REG_THROTTLE_CH  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [US_W-1:0]    min_us;
        logic [US_W-1:0]    max_us;
        logic [US_W-1:0]    center_us;
        logic [DB_W-1:0]    band_half_us;
        logic [ALPHA_W-1:0] alpha_q8;
        logic [US_W-1:0]    fs_throttle_us;
        logic [CH_W-1:0]    throttle_channel;
    } cfg_t;

    localparam logic [US_W-1:0]    RST_MIN_US       = 12'd1000;
    localparam logic [US_W-1:0]    RST_MAX_US       = 12'd2000;
    localparam logic [US_W-1:0]    RST_CENTER_US    = 12'd1500;
    localparam logic [DB_W-1:0]    RST_BAND_HALF_US = 8'd10;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_Q8     = 9'd128;
    localparam logic [US_W-1:0]    RST_FS_THROTTLE  = 12'd1000;
    localparam logic [CH_W-1:0]    RST_THROTTLE_CH  = 3'd2;

endpackage

// ===== hdl/ccds_in_if.sv =====
// Sample command channel: valid/ready plus command, channel and raw pulse width.
// Depends on ccds_pkg for field widths.
interface ccds_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic [ccds_pkg::CH_W-1:0] channel;
    logic [ccds_pkg::US_W-1:0] raw_us;

    modport source (output valid, output cmd, output channel, output raw_us, input ready);
    modport sink   (input valid, input cmd, input channel, input raw_us, output ready);
endinterface

// ===== hdl/ccds_out_if.sv =====
// Result channel: valid/ready plus channel, conditioned width and failsafe flag.
// Depends on ccds_pkg for field widths.
interface ccds_out_if;
    logic                      valid;
    logic                      ready;
    logic [ccds_pkg::CH_W-1:0] out_channel;
    logic [ccds_pkg::US_W-1:0] value_us;
    logic                      is_failsafe;

    modport source (output valid, output out_channel, output value_us, output is_failsafe,
                    input ready);
    modport sink   (input valid, input out_channel, input value_us, input is_failsafe,
                    output ready);
endinterface

// ===== hdl/ccds_cfg_if.sv =====
// Configuration write channel: valid/ready plus register index and write data.
// Depends on ccds_pkg for field widths.
interface ccds_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ccds_pkg::CFG_IDX_W-1:0]  index;
    logic [ccds_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/channel_clamp_deadband_smoother_unit.sv =====
// Channel clamp / deadband / EMA smoother, top level.
// Path: an accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while results.ready is high; the multiply-add in ccds_condition is combinational.
// Reset: async active-low; the config registers load their defaults and every filter entry
// holds center (1500 us) in Q12.8. A reset command refills all entries from the configured center_us.
module channel_clamp_deadband_smoother_unit (
    input  logic      clk,
    input  logic      rst_n,
    ccds_in_if.sink   samples,
    ccds_out_if.source results,
    ccds_cfg_if.sink  cfg
);

    ccds_pkg::cfg_t cfg_reg;

    logic                              s1_valid_reg;
    logic [1:0]                        s1_cmd_reg;
    logic [ccds_pkg::CH_W-1:0]         s1_ch_reg;
    logic [ccds_pkg::US_W-1:0]         s1_raw_reg;

    logic [ccds_pkg::FILT_W-1:0]       filt_reg [ccds_pkg::CHANNELS];

    logic                              out_valid_reg;
    logic [ccds_pkg::CH_W-1:0]         out_ch_reg;
    logic [ccds_pkg::US_W-1:0]         out_value_reg;
    logic                              out_fs_reg;

    logic                              in_fire;
    logic                              ch_ok;
    logic                              is_sample;
    logic                              is_failsafe;
    logic                              is_reset;
    logic                              s1_has_res;
    logic                              s1_adv;
    logic [ccds_pkg::CH_IDX_W-1:0]     ch_idx;
    logic [ccds_pkg::FILT_W-1:0]       filt_cur;
    logic [ccds_pkg::FILT_W-1:0]       filt_new;
    logic [ccds_pkg::US_W-1:0]         cond_value;
    logic [ccds_pkg::US_W-1:0]         fs_value;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_us           <= ccds_pkg::RST_MIN_US;
            cfg_reg.max_us           <= ccds_pkg::RST_MAX_US;
            cfg_reg.center_us        <= ccds_pkg::RST_CENTER_US;
            cfg_reg.band_half_us     <= ccds_pkg::RST_BAND_HALF_US;
            cfg_reg.alpha_q8         <= ccds_pkg::RST_ALPHA_Q8;
            cfg_reg.fs_throttle_us   <= ccds_pkg::RST_FS_THROTTLE;
            cfg_reg.throttle_channel <= ccds_pkg::RST_THROTTLE_CH;
        end
        else if (cfg.valid)
        begin
            unique case (ccds_pkg::reg_idx_t'(cfg.index))
                ccds_pkg::REG_MIN_US:       cfg_reg.min_us       <= cfg.data;
                ccds_pkg::REG_MAX_US:       cfg_reg.max_us       <= cfg.data;
                ccds_pkg::REG_CENTER_US:    cfg_reg.center_us    <= cfg.data;
                ccds_pkg::REG_BAND_HALF_US: cfg_reg.band_half_us <= cfg.data[7:0];
                ccds_pkg::REG_ALPHA_Q8:     cfg_reg.alpha_q8     <= cfg.data[8:0];
                ccds_pkg::REG_FS_THROTTLE:  cfg_reg.fs_throttle_us   <= cfg.data;
                ccds_pkg::REG_THROTTLE_CH:  cfg_reg.throttle_channel <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // decode the word held in the input register
    always_comb
    begin
        is_sample   = 1'b0;
        is_failsafe = 1'b0;
        is_reset    = 1'b0;
        unique case (ccds_pkg::cmd_t'(s1_cmd_reg))
            ccds_pkg::CMD_SAMPLE:   is_sample   = 1'b1;
            ccds_pkg::CMD_FAILSAFE: is_failsafe = 1'b1;
            ccds_pkg::CMD_RESET:    is_reset    = 1'b1;
            default: ;
        endcase
    end

    assign ch_ok      = {2'b0, s1_ch_reg} < ccds_pkg::CH_COUNT;
    assign s1_has_res = s1_valid_reg && ch_ok && (is_sample || is_failsafe);
    assign s1_adv     = s1_valid_reg && (!s1_has_res || !out_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign in_fire    = samples.valid && samples.ready;

    assign ch_idx   = ccds_pkg::CH_IDX_W'(s1_ch_reg);
    assign filt_cur = ch_ok ? filt_reg[ch_idx] : '0;
    assign fs_value = (s1_ch_reg == cfg_reg.throttle_channel)
                    ? cfg_reg.fs_throttle_us : cfg_reg.center_us;

    ccds_condition u_condition (
        .cfg      (cfg_reg),
        .raw_us   (s1_raw_reg),
        .filt_cur (filt_cur),
        .filt_new (filt_new),
        .value_us (cond_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg <= samples.cmd;
            s1_ch_reg  <= samples.channel;
            s1_raw_reg <= samples.raw_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ccds_pkg::CHANNELS; k++)
                filt_reg[k] <= {ccds_pkg::RST_CENTER_US, 8'b0};
        end
        else if (s1_adv && is_reset)
        begin
            for (int k = 0; k < ccds_pkg::CHANNELS; k++)
                filt_reg[k] <= {cfg_reg.center_us, 8'b0};
        end
        else if (s1_adv && is_sample && ch_ok)
            filt_reg[ch_idx] <= filt_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_has_res)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_res)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_value_reg <= is_failsafe ? fs_value : cond_value;
            out_fs_reg    <= is_failsafe;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_ch_reg;
    assign results.value_us    = out_value_reg;
    assign results.is_failsafe = out_fs_reg;

endmodule

// ===== hdl/ccds_condition.sv =====
// Sample conditioning datapath: clamp, deadband snap and EMA update, all combinational.
// Depends on ccds_pkg for the configuration struct and widths.
module ccds_condition (
    input  ccds_pkg::cfg_t                  cfg,
    input  logic [ccds_pkg::US_W-1:0]       raw_us,
    input  logic [ccds_pkg::FILT_W-1:0]     filt_cur,
    output logic [ccds_pkg::FILT_W-1:0]     filt_new,
    output logic [ccds_pkg::US_W-1:0]       value_us
);

    logic [ccds_pkg::US_W-1:0]    clamped;
    logic [ccds_pkg::US_W-1:0]    lo_edge;
    logic [ccds_pkg::US_W:0]      hi_edge;
    logic [ccds_pkg::US_W-1:0]    snapped;
    logic [ccds_pkg::ALPHA_W-1:0] alpha;
    logic signed [20:0]           diff;
    logic signed [30:0]           prod;
    logic signed [30:0]           acc;
    logic [30:0]                  acc_rnd;
    logic [20:0]                  out_rnd;

    always_comb
    begin
        // min is checked first, so an inverted range still behaves
        if (raw_us < cfg.min_us)
            clamped = cfg.min_us;
        else if (raw_us > cfg.max_us)
            clamped = cfg.max_us;
        else
            clamped = raw_us;
    end

    assign lo_edge = (cfg.center_us >= {4'b0, cfg.band_half_us})
                   ? cfg.center_us - {4'b0, cfg.band_half_us} : '0;
    assign hi_edge = {1'b0, cfg.center_us} + {5'b0, cfg.band_half_us};
    assign snapped = (clamped >= lo_edge && {1'b0, clamped} <= hi_edge)
                   ? cfg.center_us : clamped;

    assign alpha = (cfg.alpha_q8 > ccds_pkg::ALPHA_ONE) ? ccds_pkg::ALPHA_ONE : cfg.alpha_q8;

    // a*v + (1-a)*s  ==  s + a*(v - s), one multiplier
    assign diff    = $signed({1'b0, snapped, 8'b0}) - $signed({1'b0, filt_cur});
    assign prod    = $signed({1'b0, alpha}) * diff;
    assign acc     = $signed({3'b0, filt_cur, 8'b0}) + prod;
    assign acc_rnd = acc + 31'sd128;
    assign filt_new = acc_rnd[27:8];

    assign out_rnd  = {1'b0, filt_new} + 21'd128;
    assign value_us = out_rnd[19:8];

endmodule
